>>> rtl/core/isf_pkg.sv
// Shared types, constants and lookup functions for the Ising spin-flip step.
// No dependencies; imported by every module of the block.
package isf_pkg;

	localparam int SIDE_W = 6;
	localparam int LEN_W = 7;
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int DEPTH = 1 << ADDR_W;
	localparam int DRAW_W = 17;
	localparam int DE_W = 27;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [LEN_W-1:0] MAX_SIDE = 7'd64;
	localparam logic [1:0] MAX_RADIUS = 2'd3;
	localparam logic [16:0] ACCEPT_SCALE = 17'd100000;
	localparam logic [32:0] X_LIMIT = 33'd786432;

	localparam logic [CFG_IDX_W-1:0] REG_SIDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FLIP = 1'b1;

	typedef struct packed {
		logic              op;
		logic [SIDE_W-1:0] row;
		logic [SIDE_W-1:0] col;
		logic              spin;
		logic [DRAW_W-1:0] draw;
	} isf_item_t;

	// twice the neighbor count q
	function automatic logic [6:0] isf_q2(input logic [1:0] rad);
		case (rad)
			2'd1: isf_q2 = 7'd16;
			2'd2: isf_q2 = 7'd48;
			2'd3: isf_q2 = 7'd96;
			default: isf_q2 = 7'd16;
		endcase
	endfunction

	// 65536/(1+exp(k/2)), rounded
	function automatic logic [15:0] isf_logi(input logic [4:0] k);
		case (k)
			5'd0: isf_logi = 16'd32768;
			5'd1: isf_logi = 16'd24743;
			5'd2: isf_logi = 16'd17625;
			5'd3: isf_logi = 16'd11955;
			5'd4: isf_logi = 16'd7812;
			5'd5: isf_logi = 16'd4971;
			5'd6: isf_logi = 16'd3108;
			5'd7: isf_logi = 16'd1921;
			5'd8: isf_logi = 16'd1179;
			5'd9: isf_logi = 16'd720;
			5'd10: isf_logi = 16'd439;
			5'd11: isf_logi = 16'd267;
			5'd12: isf_logi = 16'd162;
			5'd13: isf_logi = 16'd98;
			5'd14: isf_logi = 16'd60;
			5'd15: isf_logi = 16'd36;
			5'd16: isf_logi = 16'd22;
			5'd17: isf_logi = 16'd13;
			5'd18: isf_logi = 16'd8;
			5'd19: isf_logi = 16'd5;
			5'd20: isf_logi = 16'd3;
			5'd21: isf_logi = 16'd2;
			5'd22: isf_logi = 16'd1;
			5'd23: isf_logi = 16'd1;
			default: isf_logi = 16'd0;
		endcase
	endfunction

endpackage

>>> rtl/core/isf_front.sv
// Front end: accepts input transactions and reduces row/column modulo the side.
// Depends on isf_pkg.
module isf_front import isf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [SIDE_W-1:0] row,
	input  logic [SIDE_W-1:0] column,
	input  logic              spin_in,
	input  logic [DRAW_W-1:0] random_draw,
	input  logic [LEN_W-1:0]  len,
	output logic              push,
	output isf_item_t         push_item,
	input  logic              full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MOD  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t     state_q;
	isf_item_t   item_q;
	logic [LEN_W-1:0] rrem_q, crem_q;
	logic [2:0]  cnt_q;
	logic [LEN_W-1:0] rt, ct, rn, cn;

	// one restoring remainder step per cycle, row and column side by side
	always_comb begin
		rt = {rrem_q[SIDE_W-1:0], item_q.row[cnt_q]};
		ct = {crem_q[SIDE_W-1:0], item_q.col[cnt_q]};
		rn = (rt >= len) ? rt - len : rt;
		cn = (ct >= len) ? ct - len : ct;
	end

	assign in_stall = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= 3'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_MOD;
						cnt_q <= 3'(SIDE_W - 1);
					end
				end
				F_MOD: begin
					if (cnt_q == 3'd0) state_q <= F_PUSH;
					else cnt_q <= cnt_q - 3'd1;
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			item_q.op <= operation;
			item_q.row <= row;
			item_q.col <= column;
			item_q.spin <= spin_in;
			item_q.draw <= random_draw;
			rrem_q <= '0;
			crem_q <= '0;
		end else if (state_q == F_MOD) begin
			rrem_q <= rn;
			crem_q <= cn;
			if (cnt_q == 3'd0) begin
				item_q.row <= rn[SIDE_W-1:0];
				item_q.col <= cn[SIDE_W-1:0];
			end
		end
	end

endmodule

>>> rtl/core/isf_queue.sv
// Two-entry queue between front end and back end.
// Depends on isf_pkg.
module isf_queue import isf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  isf_item_t push_item,
	output logic      full,
	input  logic      pop,
	output isf_item_t pop_item,
	output logic      empty
);

	isf_item_t  ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_item = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_item;
	end

endmodule

>>> rtl/core/isf_back.sv
// Back end: spin store, neighbor scan, rounding divider, acceptance test, result register.
// Depends on isf_pkg.
module isf_back import isf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	input  isf_item_t              pop_item,
	output logic                   pop,
	input  logic [LEN_W-1:0]       len,
	input  logic [1:0]             rad,
	input  logic signed [23:0]     field,
	input  logic signed [23:0]     coup,
	input  logic [22:0]            beta,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   spin_out,
	output logic                   flipped,
	output logic signed [DE_W-1:0] energy_change
);

	typedef enum logic [12:0] {
		B_IDLE  = 13'b0000000000001,
		B_SETUP = 13'b0000000000010,
		B_SCAN  = 13'b0000000000100,
		B_DRAIN = 13'b0000000001000,
		B_MULJ  = 13'b0000000010000,
		B_DINIT = 13'b0000000100000,
		B_DIV   = 13'b0000001000000,
		B_TCALC = 13'b0000010000000,
		B_MUL1  = 13'b0000100000000,
		B_MUL2  = 13'b0001000000000,
		B_XCALC = 13'b0010000000000,
		B_LOGI  = 13'b0100000000000,
		B_DEC   = 13'b1000000000000
	} bstate_t;

	bstate_t state_q;
	logic    outst_q;

	logic spin_mem [DEPTH];
	logic rd_q;
	logic re, we;
	logic [ADDR_W-1:0] raddr, waddr;

	isf_item_t          item_q;
	logic               s_q;
	logic signed [7:0]  rs_q, cs_q;
	logic [SIDE_W-1:0]  rr_q, cc_q, rstart_q, cstart_q;
	logic [2:0]         di_q, dj_q;
	logic               pend_s1, skip_s1;
	logic signed [6:0]  sum_q;
	logic signed [30:0] num_q;
	logic               neg_q;
	logic [30:0]        dvd_q;
	logic [7:0]         rem_q;
	logic [4:0]         dcnt_q;
	logic signed [DE_W-1:0] de_q;
	logic [35:0]        plo_q, phi_q;
	logic               big_q;
	logic [4:0]         k_q;
	logic [14:0]        fr_q;
	logic [15:0]        p_q;
	logic               spin_new_q, flip_q;
	logic               out_valid_q, spin_out_q, flipped_q;
	logic signed [DE_W-1:0] de_out_q;

	logic signed [7:0]  len8;
	logic [2:0]         span, rad3;
	logic [6:0]         q2;
	logic signed [30:0] j_ext, s_ext, mag;
	logic [7:0]         dt;
	logic               dge;
	logic signed [27:0] qs, t28, de28;
	logic [48:0]        prod;
	logic [32:0]        xv;
	logic [15:0]        la, lb, ldiff;
	logic [30:0]        lm;
	logic [32:0]        lhs, rhs;
	logic               load_out;

	function automatic logic [SIDE_W-1:0] wrap_inc(input logic [SIDE_W-1:0] v,
		input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] nx;
		nx = {1'b0, v} + 7'd1;
		wrap_inc = (nx == n) ? '0 : nx[SIDE_W-1:0];
	endfunction

	always_comb begin
		len8 = {1'b0, len};
		rad3 = {1'b0, rad};
		span = {rad, 1'b0};
		q2 = isf_q2(rad);
		j_ext = {{7{coup[23]}}, coup};
		s_ext = {{24{sum_q[6]}}, sum_q};
		mag = neg_q ? -num_q : num_q;
		dt = {rem_q[6:0], dvd_q[30]};
		dge = (dt >= {1'b0, q2});
		qs = neg_q ? -$signed(dvd_q[27:0]) : $signed(dvd_q[27:0]);
		t28 = {{4{field[23]}}, field} + qs;
		de28 = s_q ? (t28 <<< 1) : -(t28 <<< 1);
		prod = {13'd0, plo_q} + {phi_q, 13'd0};
		xv = prod[48:16];
		la = isf_logi(k_q);
		lb = isf_logi(k_q + 5'd1);
		ldiff = la - lb;
		lm = {15'd0, ldiff} * {16'd0, fr_q};
		lhs = {item_q.draw, 16'd0};
		rhs = {16'd0, ACCEPT_SCALE} * {17'd0, p_q};
	end

	assign pop = (state_q == B_IDLE) && !empty && !outst_q;
	assign load_out = outst_q && (!out_valid_q || !out_stall);
	assign re = pop || (state_q == B_SCAN);
	assign raddr = (state_q == B_SCAN) ? {rr_q, cc_q} : {pop_item.row, pop_item.col};
	assign we = load_out;
	assign waddr = {item_q.row, item_q.col};

	// spin store: one write and one registered read per cycle; no reset
	always_ff @(posedge clk) begin
		if (we) spin_mem[waddr] <= spin_new_q;
		if (re) rd_q <= spin_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			outst_q <= 1'b0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == B_SCAN);
			if (load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (load_out) outst_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (pop_item.op == OP_WRITE) outst_q <= 1'b1;
						else state_q <= B_SETUP;
					end
				end
				B_SETUP: begin
					if (!rs_q[7] && !cs_q[7]) state_q <= B_SCAN;
				end
				B_SCAN: begin
					if (dj_q == span && di_q == span) state_q <= B_DRAIN;
				end
				B_DRAIN: state_q <= B_MULJ;
				B_MULJ: state_q <= B_DINIT;
				B_DINIT: state_q <= B_DIV;
				B_DIV: begin
					if (dcnt_q == 5'd0) state_q <= B_TCALC;
				end
				B_TCALC: begin
					if (de28[27]) begin
						outst_q <= 1'b1;
						state_q <= B_IDLE;
					end else begin
						state_q <= B_MUL1;
					end
				end
				B_MUL1: state_q <= B_MUL2;
				B_MUL2: state_q <= B_XCALC;
				B_XCALC: state_q <= B_LOGI;
				B_LOGI: state_q <= B_DEC;
				B_DEC: begin
					outst_q <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 && !skip_s1) sum_q <= sum_q + (rd_q ? 7'sd1 : -7'sd1);
		skip_s1 <= (di_q == rad3) && (dj_q == rad3);
		if (load_out) begin
			spin_out_q <= spin_new_q;
			flipped_q <= flip_q;
			de_out_q <= de_q;
		end
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					item_q <= pop_item;
					spin_new_q <= pop_item.spin;
					flip_q <= 1'b0;
					de_q <= '0;
					rs_q <= $signed({2'b00, pop_item.row}) - $signed({6'd0, rad});
					cs_q <= $signed({2'b00, pop_item.col}) - $signed({6'd0, rad});
				end
			end
			B_SETUP: begin
				// center spin was read on pop; start corner wraps onto the torus
				s_q <= rd_q;
				if (rs_q[7]) rs_q <= rs_q + len8;
				if (cs_q[7]) cs_q <= cs_q + len8;
				rr_q <= rs_q[SIDE_W-1:0];
				cc_q <= cs_q[SIDE_W-1:0];
				rstart_q <= rs_q[SIDE_W-1:0];
				cstart_q <= cs_q[SIDE_W-1:0];
				di_q <= 3'd0;
				dj_q <= 3'd0;
				sum_q <= '0;
			end
			B_SCAN: begin
				if (dj_q == span) begin
					dj_q <= 3'd0;
					cc_q <= cstart_q;
					di_q <= di_q + 3'd1;
					rr_q <= wrap_inc(rr_q, len);
				end else begin
					dj_q <= dj_q + 3'd1;
					cc_q <= wrap_inc(cc_q, len);
				end
			end
			B_MULJ: begin
				num_q <= j_ext * s_ext;
				neg_q <= sum_q[6] ^ coup[23];
			end
			B_DINIT: begin
				neg_q <= num_q[30];
				dvd_q <= {mag[29:0], 1'b0} + {25'd0, q2[6:1]};
				rem_q <= '0;
				dcnt_q <= 5'd30;
			end
			B_DIV: begin
				rem_q <= dge ? dt - {1'b0, q2} : dt;
				dvd_q <= {dvd_q[29:0], dge};
				dcnt_q <= dcnt_q - 5'd1;
			end
			B_TCALC: begin
				de_q <= de28[DE_W-1:0];
				if (de28[27]) begin
					flip_q <= 1'b1;
					spin_new_q <= ~s_q;
				end
			end
			B_MUL1: plo_q <= {13'd0, beta} * {23'd0, de_q[12:0]};
			B_MUL2: phi_q <= {13'd0, beta} * {23'd0, de_q[25:13]};
			B_XCALC: begin
				big_q <= (xv >= X_LIMIT);
				k_q <= xv[19:15];
				fr_q <= xv[14:0];
			end
			B_LOGI: p_q <= big_q ? 16'd0 : la - lm[30:15];
			B_DEC: begin
				flip_q <= (lhs < rhs);
				spin_new_q <= s_q ^ (lhs < rhs);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign spin_out = spin_out_q;
	assign flipped = flipped_q;
	assign energy_change = de_out_q;

endmodule

>>> rtl/core/ising_spin_flip_step_top.sv
// Top level of the Ising spin-flip step: configuration registers, front end,
// queue and back end. Depends on isf_pkg, isf_front, isf_queue, isf_back.
//
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  operation, row, column, spin_in, random_draw
// result   out        out_valid / out_stall spin_out, flipped, energy_change
// config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A flip attempt's duration is set mostly by the neighbor scan (one spin store read
// a cycle, (2R+1)^2 reads) and the 31-step rounding divider.
// The front end reduces the next site while the back end works; two items queue.
// Reset clears control state only; the spin store holds garbage until written.
// Result register lets the back end finish while the result waits under stall.
module ising_spin_flip_step_top import isf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic [SIDE_W-1:0]      row,
	input  logic [SIDE_W-1:0]      column,
	input  logic                   spin_in,
	input  logic [DRAW_W-1:0]      random_draw,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   spin_out,
	output logic                   flipped,
	output logic signed [DE_W-1:0] energy_change,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [6:0]         side_q;
	logic [1:0]         radius_q;
	logic signed [23:0] field_q, coup_q;
	logic [22:0]        beta_q;
	logic [LEN_W-1:0]   len;
	logic [1:0]         rad;
	logic               push, full, pop, empty;
	isf_item_t          push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 7'd64;
			radius_q <= 2'd1;
			field_q <= '0;
			coup_q <= 24'sd65536;
			beta_q <= 23'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIDE: side_q <= cfg_data[6:0];
				REG_RADIUS: radius_q <= cfg_data[1:0];
				REG_FIELD: field_q <= cfg_data;
				REG_COUPLING: coup_q <= cfg_data;
				REG_BETA: beta_q <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// clamp register values to the ranges in use
	always_comb begin
		if (side_q == 7'd0) len = 7'd1;
		else if (side_q > MAX_SIDE) len = MAX_SIDE;
		else len = side_q;
		rad = (radius_q == 2'd0) ? 2'd1 : ((radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q);
	end

	isf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .row(row), .column(column), .spin_in(spin_in),
		.random_draw(random_draw), .len(len), .push(push), .push_item(push_item),
		.full(full)
	);

	isf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .full(full),
		.pop(pop), .pop_item(pop_item), .empty(empty)
	);

	isf_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .pop_item(pop_item), .pop(pop),
		.len(len), .rad(rad), .field(field_q), .coup(coup_q), .beta(beta_q),
		.out_valid(out_valid), .out_stall(out_stall), .spin_out(spin_out),
		.flipped(flipped), .energy_change(energy_change)
	);

endmodule
